// ===== rtl/dst_pkg.sv =====
// Shared types and constants for the downbeat score tracker.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package dst_pkg;

    // Default bar length in beats
    localparam int BPB_DEFAULT = 4;

    // Configuration register indexes
    localparam logic [1:0] CFG_WRAP_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_SCORE_LEAK     = 2'd1;
    localparam logic [1:0] CFG_SWITCH_MARGIN  = 2'd2;

    // Configuration reset values
    localparam logic [15:0] WRAP_THRESHOLD_RST = 16'd32768;
    localparam logic [15:0] SCORE_LEAK_RST     = 16'd58982;
    localparam logic [15:0] SWITCH_MARGIN_RST  = 16'd4506;

    // One half in Q0.16, saturated score and confidence values
    localparam logic [15:0] HALF_PHASE    = 16'd32768;
    localparam logic [31:0] SCORE_MAX     = 32'hFFFF_FFFF;
    localparam logic [15:0] CONF_FULL     = 16'hFFFF;

    // Quotient bits produced by the shared divider
    localparam int DIV_STEPS = 16;

    typedef struct packed {
        logic [15:0] beat_phase;
        logic        beat_flag;
        logic        lock_flag;
        logic [15:0] accent_level;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  beat_in_bar;
        logic [15:0] bar_phase;
        logic        downbeat_flag;
        logic [15:0] confidence;
    } out_item_t;

    typedef struct packed {
        logic [15:0] wrap_threshold;
        logic [15:0] score_leak;
        logic [15:0] switch_margin;
    } cfg_t;

    // Divider request: remainder seed below divisor, bits shifted in MSB first
    typedef struct packed {
        logic        start;
        logic [31:0] rem_init;
        logic [15:0] shift_bits;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/dst_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on dst_pkg for the request and response types.
`default_nettype none

module dst_div
    import dst_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [31:0]      rem_reg, rem_next;
    logic [15:0]      bits_reg, bits_next;
    logic [31:0]      dvs_reg, dvs_next;
    logic [15:0]      quo_reg, quo_next;

    logic [32:0]      trial;
    logic             fits;

    // Shift one dividend bit into the remainder and try the subtract
    assign trial = {rem_reg, bits_reg[15]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        bits_next = bits_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            cnt_next  = CNT_W'(DIV_STEPS);
            rem_next  = req.rem_init;
            bits_next = req.shift_bits;
            dvs_next  = req.divisor;
            quo_next  = '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? 32'(trial - {1'b0, dvs_reg}) : trial[31:0];
            bits_next = {bits_reg[14:0], 1'b0};
            quo_next  = {quo_reg[14:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        dvs_reg  <= dvs_next;
        quo_reg  <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/dst_core.sv =====
// Sequencer, slot score file and shared multiplier of the downbeat tracker.
// Depends on dst_pkg; drives the shared divider dst_div.
`default_nettype none

module dst_core
    import dst_pkg::*;
#(
    parameter int BEATS_PER_BAR = BPB_DEFAULT
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_data,
    output div_req_t       div_req,
    input  wire div_rsp_t  div_rsp
);

    localparam int SLOT_W = $clog2(BEATS_PER_BAR);
    localparam int WU_W   = $clog2(BEATS_PER_BAR + 1);
    localparam int EXT_W  = (SLOT_W > 2) ? SLOT_W : 2;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BEATS_PER_BAR - 1);
    localparam logic [WU_W-1:0]   WU_FULL   = WU_W'(BEATS_PER_BAR);

    typedef enum logic [12:0] {
        ST_IDLE       = 13'b0_0000_0000_0001,
        ST_LEAK       = 13'b0_0000_0000_0010,
        ST_ACCENT     = 13'b0_0000_0000_0100,
        ST_ELECT_INIT = 13'b0_0000_0000_1000,
        ST_ELECT_SCAN = 13'b0_0000_0001_0000,
        ST_ELECT_MUL  = 13'b0_0000_0010_0000,
        ST_ELECT_CMP  = 13'b0_0000_0100_0000,
        ST_CLAR_SCAN  = 13'b0_0000_1000_0000,
        ST_CONF_GO    = 13'b0_0001_0000_0000,
        ST_CONF_WAIT  = 13'b0_0010_0000_0000,
        ST_PHASE_GO   = 13'b0_0100_0000_0000,
        ST_PHASE_WAIT = 13'b0_1000_0000_0000,
        ST_OUT        = 13'b1_0000_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [SLOT_W-1:0] bc_reg, bc_next;
    logic [SLOT_W-1:0] db_reg, db_next;
    logic [WU_W-1:0]   warm_reg, warm_next;
    logic [15:0]       last_phase_reg, last_phase_next;
    logic [31:0]       scores_reg [BEATS_PER_BAR];
    logic [31:0]       scores_next [BEATS_PER_BAR];

    in_item_t          item_reg, item_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] top_reg, top_next;
    logic [31:0]       top_score_reg, top_score_next;
    logic [31:0]       old_score_reg, old_score_next;
    logic [47:0]       prod_reg, prod_next;
    logic [31:0]       first_reg, first_next;
    logic [31:0]       second_reg, second_next;
    logic [15:0]       conf_reg, conf_next;
    logic [15:0]       bphase_reg, bphase_next;
    logic [SLOT_W-1:0] pos_reg, pos_next;
    logic              down_reg, down_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic [SLOT_W-1:0] rd_addr;
    logic [31:0]       rd_score;
    logic [31:0]       mul_a;
    logic [15:0]       mul_b;
    logic [47:0]       mul_p;
    logic              wrap;
    logic [SLOT_W-1:0] next_slot;
    logic [SLOT_W-1:0] acc_slot;
    logic [SLOT_W-1:0] pos_now;
    logic [32:0]       acc_sum;
    logic [EXT_W-1:0]  pos_ext;
    logic              accented;
    logic              idx_last;

    // Single read port into the score file
    always_comb
    begin
        unique case (state_reg)
            ST_ACCENT:     rd_addr = acc_slot;
            ST_ELECT_INIT: rd_addr = db_reg;
            default:       rd_addr = idx_reg;
        endcase
    end
    assign rd_score = scores_reg[rd_addr];

    // Shared multiplier: leak scaling or the election margin product
    assign mul_a = (state_reg == ST_ELECT_MUL) ? old_score_reg : rd_score;
    assign mul_b = (state_reg == ST_ELECT_MUL) ? cfg.switch_margin : cfg.score_leak;
    assign mul_p = mul_a * mul_b;

    // Signed wrap test on the new phase
    assign wrap = $signed({2'b00, in_data.beat_phase}) <
                  $signed({2'b00, last_phase_reg} - {2'b00, cfg.wrap_threshold});

    assign next_slot = (bc_reg == LAST_SLOT) ? '0 : bc_reg + 1'b1;
    assign pos_now   = (bc_reg >= db_reg) ? bc_reg - db_reg
                     : SLOT_W'({1'b0, bc_reg} + (SLOT_W+1)'(BEATS_PER_BAR) - {1'b0, db_reg});
    assign acc_sum   = {1'b0, rd_score} + 33'(item_reg.accent_level);
    assign accented  = item_reg.beat_flag && (item_reg.accent_level != '0);
    assign idx_last  = (idx_reg == LAST_SLOT);
    assign pos_ext   = EXT_W'(pos_reg);

    // Slot of this beat: the next one when an accent lands past half phase
    assign acc_slot  = (accented && (item_reg.beat_phase > HALF_PHASE)) ? next_slot : bc_reg;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        bc_next         = bc_reg;
        db_next         = db_reg;
        warm_next       = warm_reg;
        last_phase_next = last_phase_reg;
        scores_next     = scores_reg;
        item_next       = item_reg;
        slot_next       = slot_reg;
        top_next        = top_reg;
        top_score_next  = top_score_reg;
        old_score_next  = old_score_reg;
        prod_next       = prod_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        conf_next       = conf_reg;
        bphase_next     = bphase_reg;
        pos_next        = pos_reg;
        down_next       = down_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        div_req         = '0;

        unique case (state_reg)
            // Take an item, detect a wrap and advance the beat counter
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next       = in_data;
                    last_phase_next = in_data.beat_phase;
                    idx_next        = '0;
                    if (wrap)
                    begin
                        bc_next    = next_slot;
                        state_next = ST_LEAK;
                    end
                    else
                    begin
                        state_next = ST_ACCENT;
                    end
                end
            end

            // Scale one slot score per cycle
            ST_LEAK:
            begin
                scores_next[idx_reg] = mul_p[47:16];
                idx_next = idx_reg + 1'b1;
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = ST_ACCENT;
                end
            end

            // Add the accent with saturation and count warm-up
            ST_ACCENT:
            begin
                slot_next   = acc_slot;
                idx_next    = '0;
                first_next  = '0;
                second_next = '0;
                state_next  = ST_CLAR_SCAN;
                if (accented)
                begin
                    scores_next[acc_slot] = acc_sum[32] ? SCORE_MAX : acc_sum[31:0];
                    if (warm_reg < WU_FULL)
                        warm_next = warm_reg + 1'b1;
                    state_next = ST_ELECT_INIT;
                end
            end

            // Seed the election with the current downbeat score
            ST_ELECT_INIT:
            begin
                top_next       = db_reg;
                top_score_next = rd_score;
                old_score_next = rd_score;
                idx_next       = '0;
                state_next     = ST_ELECT_SCAN;
            end

            // Find the highest score; the current downbeat, then the lowest index, wins ties
            ST_ELECT_SCAN:
            begin
                if (rd_score > top_score_reg)
                begin
                    top_next       = idx_reg;
                    top_score_next = rd_score;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = ST_ELECT_MUL;
                end
            end

            ST_ELECT_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_ELECT_CMP;
            end

            // Move the downbeat when the rival clears the margin
            ST_ELECT_CMP:
            begin
                if ((top_reg != db_reg) && ({4'b0000, top_score_reg, 12'h000} > prod_reg))
                    db_next = top_reg;
                idx_next    = '0;
                first_next  = '0;
                second_next = '0;
                state_next  = ST_CLAR_SCAN;
            end

            // Track best and second-best scores
            ST_CLAR_SCAN:
            begin
                if (rd_score > first_reg)
                begin
                    second_next = first_reg;
                    first_next  = rd_score;
                end
                else if (rd_score > second_reg)
                begin
                    second_next = rd_score;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = ST_CONF_GO;
                end
            end

            // Resolve the trivial confidence cases or start a division
            ST_CONF_GO:
            begin
                if (!item_reg.lock_flag || (first_reg == '0))
                begin
                    conf_next  = '0;
                    state_next = ST_PHASE_GO;
                end
                else if (second_reg == '0)
                begin
                    conf_next  = CONF_FULL;
                    state_next = ST_PHASE_GO;
                end
                else
                begin
                    div_req.start      = 1'b1;
                    div_req.rem_init   = first_reg - second_reg;
                    div_req.shift_bits = '0;
                    div_req.divisor    = first_reg;
                    state_next         = ST_CONF_WAIT;
                end
            end

            ST_CONF_WAIT:
            begin
                if (div_rsp.done)
                begin
                    conf_next  = div_rsp.quotient;
                    state_next = ST_PHASE_GO;
                end
            end

            // Bar position and downbeat flag, then divide for bar phase
            ST_PHASE_GO:
            begin
                pos_next  = pos_now;
                down_next = item_reg.beat_flag && (slot_reg == db_reg) && (warm_reg >= WU_FULL);
                div_req.start      = 1'b1;
                div_req.rem_init   = 32'(pos_now);
                div_req.shift_bits = item_reg.beat_phase;
                div_req.divisor    = 32'(BEATS_PER_BAR);
                state_next         = ST_PHASE_WAIT;
            end

            // Wait for the divider and capture the bar phase
            ST_PHASE_WAIT:
            begin
                if (div_rsp.done)
                begin
                    bphase_next = div_rsp.quotient;
                    state_next  = ST_OUT;
                end
            end

            // Hand the result to the output register once it is free
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.beat_in_bar   = pos_ext[1:0];
                    out_data_next.bar_phase     = bphase_reg;
                    out_data_next.downbeat_flag = down_reg;
                    out_data_next.confidence    = conf_reg;
                    state_next                  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            bc_reg         <= '0;
            db_reg         <= '0;
            warm_reg       <= '0;
            last_phase_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < BEATS_PER_BAR; i++)
                scores_reg[i] <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            bc_reg         <= bc_next;
            db_reg         <= db_next;
            warm_reg       <= warm_next;
            last_phase_reg <= last_phase_next;
            out_valid_reg  <= out_valid_next;
            scores_reg     <= scores_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        slot_reg      <= slot_next;
        top_reg       <= top_next;
        top_score_reg <= top_score_next;
        old_score_reg <= old_score_next;
        prod_reg      <= prod_next;
        first_reg     <= first_next;
        second_reg    <= second_next;
        conf_reg      <= conf_next;
        bphase_reg    <= bphase_next;
        pos_reg       <= pos_next;
        down_reg      <= down_next;
        out_data_reg  <= out_data_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/downbeat_score_tracker_unit.sv =====
// Top level of the downbeat score tracker: configuration registers and wiring.
// Depends on dst_pkg, dst_div and dst_core.
`default_nettype none

// One tick item goes in, one result item comes out. The block takes a new item
// only while its sequencer is idle, so it finishes one item before taking the
// next. Walks of the score file go one slot per cycle through a single read port
// and shared 32x16 multiplier; the leak walk runs only when the phase wraps, and
// the election walk is skipped when the beat carries no accent. The shared divider
// makes 16-step passes for confidence, skipped when no division is needed
// (unlocked, all scores zero, or no runner-up), then for bar phase. A finished
// result waits in an output register, so the next item can be taken while
// downstream stalls; a result that finds that register still full waits until it
// drains. Configuration is written through cfg_valid/cfg_ready, always ready;
// unknown indexes are ignored.

module downbeat_score_tracker_unit
    import dst_pkg::*;
#(
    parameter int BEATS_PER_BAR = BPB_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cfg_t     cfg_reg, cfg_next;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WRAP_THRESHOLD: cfg_next.wrap_threshold = cfg_data;
                CFG_SCORE_LEAK:     cfg_next.score_leak     = cfg_data;
                CFG_SWITCH_MARGIN:  cfg_next.switch_margin  = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wrap_threshold <= WRAP_THRESHOLD_RST;
            cfg_reg.score_leak     <= SCORE_LEAK_RST;
            cfg_reg.switch_margin  <= SWITCH_MARGIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;

    dst_core #(
        .BEATS_PER_BAR (BEATS_PER_BAR)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

    dst_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

`default_nettype wire
